[rtl/psrf_pkg.sv]
// ----------------------------------------------------------------------------
// psrf_pkg
// Shared types and constants for the paired shadow register flush block.
// ----------------------------------------------------------------------------
package psrf_pkg;

   localparam int REGS_PER_CHIP = 32;
   localparam int REG_W         = 5;
   localparam int CS_W          = 8;

   // command codes on the request side
   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_FLUSH = 2'd1,
      CMD_FORCE = 2'd2,
      CMD_RESET = 2'd3
   } cmd_op_type;

   // classified command handed from the front to the back end
   typedef struct packed {
      cmd_op_type       op;
      logic [2:0]       chip;
      logic [REG_W-1:0] reg_idx;
      logic [7:0]       value;
      logic [1:0]       pair;
      logic             has_right;
   } back_cmd_type;

   // one bus write
   typedef struct packed {
      logic [CS_W-1:0]  chip_select;
      logic [REG_W-1:0] bus_addr;
      logic [7:0]       bus_data;
      logic             reset_active;
      logic             last;
   } rsp_type;

   // update order, voice control registers held back until late
   localparam logic [REG_W-1:0] FLUSH_ORDER [REGS_PER_CHIP] = '{
      5'd0,  5'd1,  5'd2,  5'd3,  5'd5,  5'd6,
      5'd7,  5'd8,  5'd9,  5'd10, 5'd12, 5'd13,
      5'd14, 5'd15, 5'd16, 5'd17, 5'd19, 5'd20,
      5'd4,  5'd11, 5'd18,
      5'd21, 5'd22, 5'd23, 5'd24,
      5'd25, 5'd26, 5'd27, 5'd28, 5'd29, 5'd30, 5'd31
   };

endpackage

[rtl/psrf_ram.sv]
// ----------------------------------------------------------------------------
// psrf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module psrf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/psrf_fifo.sv]
// ----------------------------------------------------------------------------
// psrf_fifo
// Small flop based first-in first-out queue.
// ----------------------------------------------------------------------------
module psrf_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/psrf_front.sv]
// ----------------------------------------------------------------------------
// psrf_front
// Request decode: drops writes to absent chips and flushes of absent pairs,
// works out whether a pair has its right chip, and queues the rest.
// ----------------------------------------------------------------------------
module psrf_front #(
   parameter int NUM_CHIPS = 2
) (
   input  logic                  push,
   output logic                  full,
   input  logic [1:0]            req_cmd,
   input  logic [2:0]            req_chip_index,
   input  logic [4:0]            req_reg_index,
   input  logic [7:0]            req_reg_value,
   input  logic [1:0]            req_pair_index,
   output logic                  q_push,
   output psrf_pkg::back_cmd_type q_data,
   input  logic                  q_full
);

   import psrf_pkg::*;

   localparam logic [3:0] NCHIPS = 4'(NUM_CHIPS);

   cmd_op_type op;
   logic       keep;

   assign op = cmd_op_type'(req_cmd);

   always_comb begin
      case (op)
         CMD_WRITE: keep = ({1'b0, req_chip_index} < NCHIPS);
         CMD_FLUSH: keep = ({1'b0, req_pair_index, 1'b0} < NCHIPS);
         default:   keep = 1'b1;
      endcase
   end

   always_comb begin
      q_data.op        = op;
      q_data.chip      = req_chip_index;
      q_data.reg_idx   = req_reg_index;
      q_data.value     = req_reg_value;
      q_data.pair      = req_pair_index;
      q_data.has_right = ({1'b0, req_pair_index, 1'b1} < NCHIPS);
   end

   // dropped items are still taken from the requester
   assign full   = q_full;
   assign q_push = push && !q_full && keep;

endmodule

[rtl/psrf_back.sv]
// ----------------------------------------------------------------------------
// psrf_back
// Command engine: register file writes, force, reset write and the pair
// flush sequencer with its shadow compare.
// ----------------------------------------------------------------------------
module psrf_back #(
   parameter int NUM_CHIPS = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_empty,
   output logic                   cmd_pop,
   input  psrf_pkg::back_cmd_type cmd_data,
   output logic                   out_push,
   output psrf_pkg::rsp_type      out_data,
   input  logic                   out_full
);

   import psrf_pkg::*;

   localparam int NPAIRS = (NUM_CHIPS + 1) / 2;
   localparam int DEPTH  = NPAIRS * REGS_PER_CHIP;
   localparam int AW     = $clog2(DEPTH);
   localparam int IW     = $clog2(REGS_PER_CHIP + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WR_READ,
      ST_WR_COMMIT,
      ST_FLUSH,
      ST_RESET
   } state_type;

   state_type        state_ff, state_in;
   back_cmd_type     cmd_ff, cmd_in;
   logic [IW-1:0]    idx_ff, idx_in;
   logic             ev_valid_ff, ev_valid_in;
   logic [REG_W-1:0] ev_reg_ff, ev_reg_in;
   logic             ev_lval_ff, ev_lval_in;
   logic             ev_lfrc_ff, ev_lfrc_in;
   logic             ev_rval_ff, ev_rval_in;
   logic             ev_rfrc_ff, ev_rfrc_in;
   logic             second_ff, second_in;
   logic             hold_valid_ff, hold_valid_in;
   rsp_type          hold_ff, hold_in;
   logic [1:0][DEPTH-1:0] valid_ff, valid_in;
   logic [1:0][DEPTH-1:0] forced_ff, forced_in;

   // bank 0 holds even chips, bank 1 odd chips
   logic [1:0]       work_we, shad_we;
   logic [1:0][7:0]  work_wdata, shad_wdata, work_rdata, shad_rdata;
   logic [AW-1:0]    wr_addr, rd_addr;
   logic             rd_en;

   for (genvar b = 0; b < 2; b++) begin : g_bank
      psrf_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_work (
         .clock   (clock),
         .wr_en   (work_we[b]),
         .wr_addr (wr_addr),
         .wr_data (work_wdata[b]),
         .rd_en   (rd_en),
         .rd_addr (rd_addr),
         .rd_data (work_rdata[b])
      );
      psrf_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_shad (
         .clock   (clock),
         .wr_en   (shad_we[b]),
         .wr_addr (wr_addr),
         .wr_data (shad_wdata[b]),
         .rd_en   (rd_en),
         .rd_addr (rd_addr),
         .rd_data (shad_rdata[b])
      );
   end

   logic [AW-1:0]    ev_addr, cw_addr, issue_addr;
   logic [REG_W-1:0] issue_reg;
   logic [7:0]       lw, ls, rw, rs, old_work;
   logic             l_pend, r_pend, shared, can_emit;
   logic [CS_W-1:0]  cs_l, cs_r;
   logic             emit, done, set_second, fire, advance;
   logic             wr_l, wr_r;
   rsp_type          item;
   logic             cb;

   assign ev_addr    = AW'({cmd_ff.pair, ev_reg_ff});
   assign cw_addr    = AW'({cmd_ff.chip[2:1], cmd_ff.reg_idx});
   assign issue_reg  = FLUSH_ORDER[idx_ff[REG_W-1:0]];
   assign issue_addr = AW'({cmd_ff.pair, issue_reg});
   assign cb         = cmd_ff.chip[0];

   // a forced entry reads as the inverse of its working byte
   assign lw       = ev_lval_ff ? work_rdata[0] : 8'h00;
   assign ls       = ev_lfrc_ff ? ~lw : shad_rdata[0];
   assign rw       = ev_rval_ff ? work_rdata[1] : 8'h00;
   assign rs       = ev_rfrc_ff ? ~rw : shad_rdata[1];
   assign l_pend   = (lw != ls);
   assign r_pend   = cmd_ff.has_right && (rw != rs);
   assign shared   = cmd_ff.has_right && (lw == rw);
   assign cs_l     = CS_W'(1) << {cmd_ff.pair, 1'b0};
   assign cs_r     = CS_W'(1) << {cmd_ff.pair, 1'b1};
   assign can_emit = !hold_valid_ff || !out_full;
   assign old_work = valid_ff[cb][cw_addr] ? work_rdata[cb] : 8'h00;

   // outcome of the register under evaluation
   always_comb begin
      emit       = 1'b0;
      done       = 1'b1;
      set_second = 1'b0;
      wr_l       = 1'b0;
      wr_r       = 1'b0;
      item       = '{chip_select: cs_l, bus_addr: ev_reg_ff, bus_data: lw,
                     reset_active: 1'b0, last: 1'b0};
      if (second_ff) begin
         emit             = 1'b1;
         wr_r             = 1'b1;
         item.chip_select = cs_r;
         item.bus_data    = rw;
      end else if (l_pend && shared) begin
         emit             = 1'b1;
         wr_l             = 1'b1;
         wr_r             = 1'b1;
         item.chip_select = cs_l | cs_r;
      end else if (l_pend) begin
         emit       = 1'b1;
         wr_l       = 1'b1;
         done       = !r_pend;
         set_second = r_pend;
      end else if (r_pend) begin
         emit             = 1'b1;
         wr_r             = 1'b1;
         item.chip_select = cs_r;
         item.bus_data    = rw;
      end
      fire = !emit || can_emit;
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      idx_in        = idx_ff;
      ev_valid_in   = ev_valid_ff;
      ev_reg_in     = ev_reg_ff;
      ev_lval_in    = ev_lval_ff;
      ev_lfrc_in    = ev_lfrc_ff;
      ev_rval_in    = ev_rval_ff;
      ev_rfrc_in    = ev_rfrc_ff;
      second_in     = second_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      valid_in      = valid_ff;
      forced_in     = forced_ff;
      cmd_pop       = 1'b0;
      out_push      = 1'b0;
      out_data      = hold_ff;
      work_we       = '0;
      shad_we       = '0;
      work_wdata    = '0;
      shad_wdata    = '0;
      wr_addr       = ev_addr;
      rd_addr       = issue_addr;
      rd_en         = 1'b0;
      advance       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd_data;
               case (cmd_data.op)
                  CMD_WRITE: state_in = ST_WR_READ;
                  CMD_FLUSH: begin
                     idx_in      = '0;
                     ev_valid_in = 1'b0;
                     second_in   = 1'b0;
                     state_in    = ST_FLUSH;
                  end
                  CMD_FORCE: forced_in = '1;
                  CMD_RESET: state_in = ST_RESET;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end

         ST_WR_READ: begin
            rd_en    = 1'b1;
            rd_addr  = cw_addr;
            state_in = ST_WR_COMMIT;
         end

         ST_WR_COMMIT: begin
            wr_addr                = cw_addr;
            work_we[cb]            = 1'b1;
            work_wdata[cb]         = cmd_ff.value;
            valid_in[cb][cw_addr]  = 1'b1;
            // a forced entry keeps the inverse of the byte it was forced from
            if (forced_ff[cb][cw_addr]) begin
               shad_we[cb]            = 1'b1;
               shad_wdata[cb]         = ~old_work;
               forced_in[cb][cw_addr] = 1'b0;
            end
            state_in = ST_IDLE;
         end

         ST_FLUSH: begin
            if (ev_valid_ff) begin
               if (fire) begin
                  shad_wdata[0] = lw;
                  shad_wdata[1] = rw;
                  if (wr_l) begin
                     shad_we[0]           = 1'b1;
                     forced_in[0][ev_addr] = 1'b0;
                  end
                  if (wr_r) begin
                     shad_we[1]           = 1'b1;
                     forced_in[1][ev_addr] = 1'b0;
                  end
                  if (emit) begin
                     out_push      = hold_valid_ff;
                     hold_in       = item;
                     hold_valid_in = 1'b1;
                  end
                  second_in = set_second;
                  advance   = done;
               end
            end else begin
               advance = 1'b1;
            end

            if (advance) begin
               if (idx_ff < IW'(REGS_PER_CHIP)) begin
                  rd_en       = 1'b1;
                  ev_valid_in = 1'b1;
                  ev_reg_in   = issue_reg;
                  ev_lval_in  = valid_ff[0][issue_addr];
                  ev_lfrc_in  = forced_ff[0][issue_addr];
                  ev_rval_in  = valid_ff[1][issue_addr];
                  ev_rfrc_in  = forced_ff[1][issue_addr];
                  idx_in      = idx_ff + IW'(1);
               end else begin
                  ev_valid_in = 1'b0;
                  if (!ev_valid_ff) begin
                     // walk done, the held write is the final one
                     if (!hold_valid_ff) begin
                        state_in = ST_IDLE;
                     end else if (!out_full) begin
                        out_push      = 1'b1;
                        out_data.last = 1'b1;
                        hold_valid_in = 1'b0;
                        state_in      = ST_IDLE;
                     end
                  end
               end
            end
         end

         ST_RESET: begin
            if (!out_full) begin
               out_push  = 1'b1;
               out_data  = '{chip_select: '1, bus_addr: '0, bus_data: '0,
                             reset_active: 1'b1, last: 1'b1};
               forced_in = '1;
               state_in  = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         ev_valid_ff   <= 1'b0;
         second_ff     <= 1'b0;
         hold_valid_ff <= 1'b0;
         valid_ff      <= '0;
         forced_ff     <= '1;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         ev_valid_ff   <= ev_valid_in;
         second_ff     <= second_in;
         hold_valid_ff <= hold_valid_in;
         valid_ff      <= valid_in;
         forced_ff     <= forced_in;
      end
      cmd_ff     <= cmd_in;
      ev_reg_ff  <= ev_reg_in;
      ev_lval_ff <= ev_lval_in;
      ev_lfrc_ff <= ev_lfrc_in;
      ev_rval_ff <= ev_rval_in;
      ev_rfrc_ff <= ev_rfrc_in;
      hold_ff    <= hold_in;
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result pushed into a full queue");

   a_reset_write_shape: assert property (@(posedge clock) disable iff (reset)
      (out_push && out_data.reset_active) |->
         (out_data.last && out_data.chip_select == '1))
      else $error("reset write malformed");

   a_second_only_in_flush: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> (state_ff == ST_FLUSH && ev_valid_ff))
      else $error("split write outside a flush");

   a_idle_hold_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !hold_valid_ff)
      else $error("held write left behind after a flush");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |-> (idx_ff <= IW'(REGS_PER_CHIP)))
      else $error("flush index ran past the register file");

endmodule

[rtl/paired_shadow_register_flush.sv]
// ----------------------------------------------------------------------------
// paired_shadow_register_flush
// Working and shadow register files for a set of sound chips, with a pair
// flush that turns changed bytes into bus writes.
// ----------------------------------------------------------------------------
// Both sides behave as a queue. A write item passes the idle, read and commit
// states of the engine, a force only the idle state, a reset write the idle and
// reset states. A flush walks the pair's 32 registers in update order at one
// register per cycle while the result queue has room, with an extra step for
// each register where both chips need separate writes. The pace is set by the
// shadow compare sequencer, which reads both chips' working and shadow bytes
// from banked RAMs once per register, and by the result queue when the consumer
// stalls. Writes, forces, flushes that produce nothing and flushes of absent
// pairs give no result item. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module paired_shadow_register_flush #(
   parameter int NUM_CHIPS = 2
) (
   input  logic       clock,
   input  logic       reset,
   // request queue
   input  logic       push,
   output logic       full,
   input  logic [1:0] req_cmd,
   input  logic [2:0] req_chip_index,
   input  logic [4:0] req_reg_index,
   input  logic [7:0] req_reg_value,
   input  logic [1:0] req_pair_index,
   // result queue
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_chip_select,
   output logic [4:0] rsp_bus_addr,
   output logic [7:0] rsp_bus_data,
   output logic       rsp_reset_active,
   output logic       rsp_last
);

   import psrf_pkg::*;

   localparam int CMD_W  = $bits(back_cmd_type);
   localparam int RSP_W  = $bits(rsp_type);
   // command queue lets the front keep taking items during a long flush
   localparam int CMDQ_D = 4;
   localparam int RSPQ_D = 2;

   back_cmd_type front_cmd, back_cmd;
   logic         front_push, cmdq_full, cmdq_empty, cmd_pop;
   rsp_type      eng_rsp, head_rsp;
   logic         eng_push, rspq_full;

   // decode and drop items for absent chips
   psrf_front #(.NUM_CHIPS(NUM_CHIPS)) u_front (
      .push           (push),
      .full           (full),
      .req_cmd        (req_cmd),
      .req_chip_index (req_chip_index),
      .req_reg_index  (req_reg_index),
      .req_reg_value  (req_reg_value),
      .req_pair_index (req_pair_index),
      .q_push         (front_push),
      .q_data         (front_cmd),
      .q_full         (cmdq_full)
   );

   // queue between decode and engine
   psrf_fifo #(.WIDTH(CMD_W), .DEPTH(CMDQ_D)) u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_cmd),
      .full      (cmdq_full),
      .pop       (cmd_pop),
      .pop_data  (back_cmd),
      .empty     (cmdq_empty)
   );

   // register files and flush sequencer
   psrf_back #(.NUM_CHIPS(NUM_CHIPS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmdq_empty),
      .cmd_pop   (cmd_pop),
      .cmd_data  (back_cmd),
      .out_push  (eng_push),
      .out_data  (eng_rsp),
      .out_full  (rspq_full)
   );

   // result queue, decouples the engine from the consumer
   psrf_fifo #(.WIDTH(RSP_W), .DEPTH(RSPQ_D)) u_rspq (
      .clock     (clock),
      .reset     (reset),
      .push      (eng_push),
      .push_data (eng_rsp),
      .full      (rspq_full),
      .pop       (pop),
      .pop_data  (head_rsp),
      .empty     (empty)
   );

   // oldest write item onto the ports
   assign rsp_chip_select  = head_rsp.chip_select;
   assign rsp_bus_addr     = head_rsp.bus_addr;
   assign rsp_bus_data     = head_rsp.bus_data;
   assign rsp_reset_active = head_rsp.reset_active;
   assign rsp_last         = head_rsp.last;

endmodule
